// ===== hw/rtl/ats_pkg.sv =====
package ats_pkg;

    localparam int TEXT_MAX_DEF      = 64;
    localparam int POSITION_BITS_DEF = 24;

    typedef enum logic [3:0] {
        TT_EOF       = 4'd0,
        TT_NEWLINE   = 4'd1,
        TT_COMMA     = 4'd2,
        TT_COLON     = 4'd3,
        TT_LBRACKET  = 4'd4,
        TT_RBRACKET  = 4'd5,
        TT_HASH      = 4'd6,
        TT_IDENT     = 4'd7,
        TT_REG       = 4'd8,
        TT_INT       = 4'd9,
        TT_STRING    = 4'd10,
        TT_DIRECTIVE = 4'd11,
        TT_UNKNOWN   = 4'd12
    } tok_t;

    // one result as it leaves the scanner
    typedef struct packed {
        logic        kind;
        logic [7:0]  text;
        logic [3:0]  ttype;
        logic [63:0] ival;
        logic [4:0]  regn;
        logic [23:0] line;
        logic [23:0] col;
        logic [5:0]  len;
        logic        last;
    } res_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
    endfunction

    function automatic logic [6:0] digit_val(input logic [7:0] c);
        if (is_digit(c)) return 7'(c - 8'h30);
        if ((c >= 8'h61) && (c <= 8'h7a)) return 7'(c - 8'h57);
        if ((c >= 8'h41) && (c <= 8'h5a)) return 7'(c - 8'h37);
        return 7'd99;
    endfunction

endpackage

// ===== hw/rtl/ats_core.sv =====
// Per-byte scanner: registered state, combinational step producing up to 3 results.
module ats_core #(
    parameter int TEXT_MAX      = ats_pkg::TEXT_MAX_DEF,
    parameter int POSITION_BITS = ats_pkg::POSITION_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        c,
    input  logic              eos,
    output ats_pkg::res_t     res [3],
    output logic [1:0]        res_cnt
);
    import ats_pkg::*;

    localparam int LW = $clog2(TEXT_MAX);
    localparam logic [LW-1:0] CAP = LW'(TEXT_MAX - 1);
    localparam logic [POSITION_BITS-1:0] PMAX = '1;
    localparam logic [POSITION_BITS-1:0] PONE = POSITION_BITS'(1);

    typedef enum logic [2:0] {
        M_IDLE, M_COMMENT, M_STRING, M_ESCAPE, M_NUMBER, M_DIRECTIVE, M_IDENT, M_MINUS
    } mode_t;

    mode_t mode_reg, mode_next;
    logic [POSITION_BITS-1:0] line_reg, line_next, col_reg, col_next;
    logic [POSITION_BITS-1:0] tline_reg, tline_next, tcol_reg, tcol_next;
    logic [LW-1:0] klen_reg, klen_next;
    logic [63:0]   acc_reg, acc_next;
    logic [1:0]    radix_reg, radix_next;
    logic          sign_reg, sign_next, stop_reg, stop_next, ovf_reg, ovf_next;
    logic          pend_reg, pend_next;
    logic          rw_reg, rw_next, live_reg, live_next, second_reg, second_next;
    logic [5:0]    rval_reg, rval_next;
    logic [2:0]    cand_reg, cand_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            line_reg <= PONE; col_reg <= PONE; tline_reg <= PONE; tcol_reg <= PONE;
            klen_reg <= '0; acc_reg <= '0; radix_reg <= '0; sign_reg <= 1'b0;
            stop_reg <= 1'b0; ovf_reg <= 1'b0; pend_reg <= 1'b0;
            rw_reg <= 1'b0; live_reg <= 1'b0; second_reg <= 1'b0;
            rval_reg <= '0; cand_reg <= '0;
        end else if (step) begin
            mode_reg <= mode_next;
            line_reg <= line_next; col_reg <= col_next;
            tline_reg <= tline_next; tcol_reg <= tcol_next;
            klen_reg <= klen_next; acc_reg <= acc_next; radix_reg <= radix_next;
            sign_reg <= sign_next; stop_reg <= stop_next; ovf_reg <= ovf_next;
            pend_reg <= pend_next; rw_reg <= rw_next; live_reg <= live_next;
            second_reg <= second_next; rval_reg <= rval_next; cand_reg <= cand_next;
        end
    end

    // shared number digit step
    logic [6:0]  d;
    logic [4:0]  base;
    logic [67:0] prod;
    logic [7:0]  cu;
    assign d  = digit_val(c);
    assign cu = ((c >= 8'h61) && (c <= 8'h7a)) ? c - 8'd32 : c;
    always_comb begin
        unique case (radix_reg)
            2'd0: base = 5'd10;
            2'd1: base = 5'd8;
            2'd2: base = 5'd16;
            default: base = 5'd2;
        endcase
    end
    assign prod = {4'd0, acc_reg} * {63'd0, base} + {61'd0, d};

    always_comb begin
        logic [1:0] n;
        logic [LW-1:0] idx;
        logic [63:0] v;
        logic fin_mode, idle_go, sgl, adv;
        logic [3:0] styp;

        mode_next = mode_reg;
        line_next = line_reg; col_next = col_reg;
        tline_next = tline_reg; tcol_next = tcol_reg;
        klen_next = klen_reg; acc_next = acc_reg; radix_next = radix_reg;
        sign_next = sign_reg; stop_next = stop_reg; ovf_next = ovf_reg;
        pend_next = pend_reg; rw_next = rw_reg; live_next = live_reg;
        second_next = second_reg; rval_next = rval_reg; cand_next = cand_reg;
        for (int i = 0; i < 3; i++) res[i] = '0;
        n = 2'd0; idle_go = 1'b0; fin_mode = 1'b0; adv = 1'b0;
        idx = '0; v = '0; styp = TT_UNKNOWN; sgl = 1'b0;

        // finish of the pending token (end record from current state)
        if (mode_reg == M_NUMBER) begin
            if (sign_reg) v = (ovf_reg || acc_reg > 64'h8000000000000000) ?
                              64'h8000000000000000 : 64'd0 - acc_reg;
            else v = (ovf_reg || acc_reg[63]) ? 64'h7FFFFFFFFFFFFFFF : acc_reg;
        end

        if (eos) begin
            fin_mode = (mode_reg != M_IDLE) && (mode_reg != M_COMMENT);
        end else begin
            unique case (mode_reg)
                M_COMMENT: if (c == 8'h0a) idle_go = 1'b1; else adv = 1'b1;
                M_STRING: begin
                    adv = 1'b1;
                    if (c == 8'h22) fin_mode = 1'b1;
                    else if (c == 8'h5c) mode_next = M_ESCAPE;
                    else if (klen_reg < CAP) begin
                        res[0].text = c; n = 2'd1; klen_next = klen_reg + 1'b1;
                    end
                end
                M_ESCAPE: begin
                    adv = 1'b1; mode_next = M_STRING;
                    if (klen_reg < CAP) begin
                        res[0].text = (c == 8'h6e) ? 8'd10 : (c == 8'h74) ? 8'd9 : c;
                        n = 2'd1; klen_next = klen_reg + 1'b1;
                    end
                end
                M_MINUS: begin
                    if (is_digit(c)) begin
                        adv = 1'b1; mode_next = M_NUMBER;
                        if (klen_reg < CAP) begin
                            res[0].text = c; n = 2'd1; klen_next = klen_reg + 1'b1;
                            radix_next = (d == 7'd0) ? 2'd1 : 2'd0;
                            acc_next = 64'(d);
                        end
                    end else begin
                        fin_mode = 1'b1; idle_go = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(c) || is_alpha(c)) begin
                        adv = 1'b1;
                        if (klen_reg < CAP) begin
                            res[0].text = c; n = 2'd1; klen_next = klen_reg + 1'b1;
                            idx = klen_reg - LW'(sign_reg);
                            if (!stop_reg) begin
                                if (idx == '0) begin
                                    radix_next = (d == 7'd0) ? 2'd1 : 2'd0;
                                    acc_next = 64'(d);
                                end else if (pend_reg) begin
                                    if (d < ((radix_reg == 2'd2) ? 7'd16 : 7'd2)) begin
                                        pend_next = 1'b0; acc_next = 64'(d);
                                    end else stop_next = 1'b1;
                                end else if (idx == LW'(1) && radix_reg == 2'd1 &&
                                             (c == 8'h78 || c == 8'h58)) begin
                                    radix_next = 2'd2; pend_next = 1'b1;
                                end else if (idx == LW'(1) && radix_reg == 2'd1 &&
                                             (c == 8'h62 || c == 8'h42)) begin
                                    radix_next = 2'd3; pend_next = 1'b1;
                                end else if (d >= 7'(base)) stop_next = 1'b1;
                                else if (!ovf_reg) begin
                                    if (prod[67:64] != 4'd0) ovf_next = 1'b1;
                                    else acc_next = prod[63:0];
                                end
                            end
                        end
                    end else begin
                        fin_mode = 1'b1; idle_go = 1'b1;
                    end
                end
                M_DIRECTIVE, M_IDENT: begin
                    if (is_digit(c) || is_alpha(c) || c == 8'h5f) begin
                        adv = 1'b1;
                        if (klen_reg < CAP) begin
                            res[0].text = c; n = 2'd1; klen_next = klen_reg + 1'b1;
                            if (mode_reg == M_IDENT) begin
                                if (klen_reg == LW'(1)) begin
                                    if (rw_reg) begin
                                        if (is_digit(c)) begin
                                            live_next = 1'b1; rval_next = 6'(c - 8'h30);
                                        end else rw_next = 1'b0;
                                    end
                                    if ((cand_reg == 3'd1 || cand_reg == 3'd2) ?
                                        (cu == 8'h50) : (cand_reg != 3'd0 && cu == 8'h52))
                                        second_next = 1'b1;
                                end else if (live_reg) begin
                                    if (is_digit(c)) begin
                                        rval_next = (rval_reg > 6'd3) ? 6'd32 :
                                            (rval_reg * 6'd10 + 6'(c - 8'h30) > 6'd32) ?
                                            6'd32 : rval_reg * 6'd10 + 6'(c - 8'h30);
                                    end else live_next = 1'b0;
                                end
                            end
                        end
                    end else begin
                        fin_mode = 1'b1; idle_go = 1'b1;
                    end
                end
                default: idle_go = 1'b1;
            endcase
        end

        // end record of the pending token goes first
        if (fin_mode) begin
            res[0] = '0;
            res[0].kind = 1'b1;
            res[0].line = 24'(tline_reg);
            res[0].col  = 24'(tcol_reg);
            res[0].len  = 6'(klen_reg);
            unique case (mode_reg)
                M_NUMBER: begin res[0].ttype = TT_INT; res[0].ival = v; end
                M_DIRECTIVE: res[0].ttype = TT_DIRECTIVE;
                M_MINUS: res[0].ttype = TT_UNKNOWN;
                M_IDENT: begin
                    if (rw_reg && klen_reg >= LW'(2) && rval_reg <= 6'd31) begin
                        res[0].ttype = TT_REG; res[0].regn = rval_reg[4:0];
                    end else if (cand_reg != 3'd0 && second_reg && klen_reg == LW'(2)) begin
                        res[0].ttype = TT_REG; res[0].regn = 5'(5'd27 + 5'(cand_reg));
                    end else res[0].ttype = TT_IDENT;
                end
                default: res[0].ttype = TT_STRING;
            endcase
            n = 2'd1;
            mode_next = M_IDLE;
        end

        if (adv) begin
            if (c == 8'h0a) begin
                if (line_reg != PMAX) line_next = line_reg + 1'b1;
                col_next = PONE;
            end else if (col_reg != PMAX) col_next = col_reg + 1'b1;
        end

        if (idle_go) begin
            mode_next = M_IDLE;
            // advance is common to every idle path
            if (c == 8'h0a) begin
                if (line_reg != PMAX) line_next = line_reg + 1'b1;
                col_next = PONE;
            end else if (col_reg != PMAX) col_next = col_reg + 1'b1;
            sgl = 1'b1;
            unique case (c)
                8'h0a: styp = TT_NEWLINE;
                8'h2c: styp = TT_COMMA;
                8'h3a: styp = TT_COLON;
                8'h5b: styp = TT_LBRACKET;
                8'h5d: styp = TT_RBRACKET;
                8'h23: styp = TT_HASH;
                default: sgl = 1'b0;
            endcase
            if (c == 8'h20 || c == 8'h09 || c == 8'h0d) begin
                // blank
            end else if (c == 8'h3b) begin
                mode_next = M_COMMENT;
            end else begin
                tline_next = line_reg; tcol_next = col_reg;
                klen_next = '0;
                if (!sgl) begin
                    acc_next = '0; radix_next = '0; sign_next = 1'b0; stop_next = 1'b0;
                    ovf_next = 1'b0; pend_next = 1'b0; rw_next = 1'b0; live_next = 1'b0;
                    second_next = 1'b0; rval_next = '0; cand_next = '0;
                end
                if (c == 8'h22) mode_next = M_STRING;
                else begin
                    res[n] = '0; res[n].text = c; n = n + 2'd1;
                    klen_next = LW'(1);
                    if (sgl || !(is_digit(c) || c == 8'h2d || c == 8'h2e ||
                                 is_alpha(c) || c == 8'h5f)) begin
                        res[n] = '0; res[n].kind = 1'b1; res[n].ttype = sgl ? styp : TT_UNKNOWN;
                        res[n].line = 24'(line_reg); res[n].col = 24'(col_reg);
                        res[n].len = 6'd1; n = n + 2'd1;
                    end else if (is_digit(c)) begin
                        mode_next = M_NUMBER;
                        radix_next = (d == 7'd0) ? 2'd1 : 2'd0; acc_next = 64'(d);
                    end else if (c == 8'h2d) begin
                        mode_next = M_MINUS; sign_next = 1'b1;
                    end else if (c == 8'h2e) mode_next = M_DIRECTIVE;
                    else begin
                        mode_next = M_IDENT;
                        rw_next = (cu == 8'h52 || cu == 8'h57);
                        cand_next = (cu == 8'h53) ? 3'd1 : (cu == 8'h46) ? 3'd2 :
                                    (cu == 8'h4c) ? 3'd3 : (cu == 8'h5a) ? 3'd4 : 3'd0;
                    end
                end
            end
        end

        if (eos) begin
            res[n] = '0; res[n].kind = 1'b1; res[n].ttype = TT_EOF;
            res[n].line = 24'(line_reg); res[n].col = 24'(col_reg);
            n = n + 2'd1;
            mode_next = M_IDLE;
            line_next = PONE; col_next = PONE; tline_next = PONE; tcol_next = PONE;
            klen_next = '0; acc_next = '0; radix_next = '0; sign_next = 1'b0;
            stop_next = 1'b0; ovf_next = 1'b0; pend_next = 1'b0; rw_next = 1'b0;
            live_next = 1'b0; second_next = 1'b0; rval_next = '0; cand_next = '0;
        end
        if (n != 2'd0) res[n - 2'd1].last = 1'b1;
        res_cnt = n;
    end

endmodule

// ===== hw/rtl/assembler_token_scanner_top.sv =====
// Assembly source lexer.
// Slave channel: one source byte per transfer, tuser = end of source.
// Master channel: token text bytes (tuser kind 0) followed by an end record
// (kind 1) carrying type, value, register, start position and text length;
// tlast marks the last result caused by one input transfer.
// Each input produces 0 to 3 results. The scanner steps once per accepted
// byte; results go into a 3-entry holding buffer and leave one per cycle
// while m_axis_tready is high. A new byte is taken in the cycle that the
// buffer drains its last entry, so with tready high runs of one-result bytes
// move at one byte per cycle; a byte with two or three results holds off
// the next until its last leaves; results start in the cycle after the transfer.
// Reset (aresetn low, synchronous) returns the scanner to line 1 column 1
// and empties the buffer. While m_axis_tready is low, results hold and
// s_axis_tready drops once the buffer is occupied and not draining.
// End of source emits the pending token, then an EOF record, and restarts.
module assembler_token_scanner_top #(
    parameter int TEXT_MAX      = ats_pkg::TEXT_MAX_DEF,
    parameter int POSITION_BITS = ats_pkg::POSITION_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // source_byte
    input  logic          s_axis_tuser,   // end_of_source
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // text_byte[7:0], token_type[11:8], int_value[75:12], reg_number[80:76],
    // start_line[104:81], start_column[128:105], text_length[134:129], pad
    output logic [135:0]  m_axis_tdata,
    output logic          m_axis_tuser,   // result_kind
    output logic          m_axis_tlast    // last_of_run
);
    import ats_pkg::*;

    res_t       res [3];
    logic [1:0] res_cnt;
    logic       take;

    res_t       buf_reg [3];
    logic [1:0] cnt_reg, pos_reg;
    logic       drain;

    ats_core #(.TEXT_MAX(TEXT_MAX), .POSITION_BITS(POSITION_BITS)) u_core (
        .aclk(aclk), .aresetn(aresetn), .step(take),
        .c(s_axis_tdata), .eos(s_axis_tuser), .res(res), .res_cnt(res_cnt)
    );

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign drain = m_axis_tvalid && m_axis_tready && (pos_reg + 2'd1 == cnt_reg);
    assign s_axis_tready = (cnt_reg == 2'd0) || drain;
    assign take = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            pos_reg <= 2'd0;
        end else if (take) begin
            cnt_reg <= res_cnt;
            pos_reg <= 2'd0;
        end else if (drain) begin
            cnt_reg <= 2'd0;
            pos_reg <= 2'd0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            pos_reg <= pos_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            for (int i = 0; i < 3; i++) buf_reg[i] <= res[i];
        end
    end

    res_t cur;
    always_comb begin
        unique case (pos_reg)
            2'd0: cur = buf_reg[0];
            2'd1: cur = buf_reg[1];
            default: cur = buf_reg[2];
        endcase
    end

    assign m_axis_tdata = {1'b0, cur.len, cur.col, cur.line, cur.regn, cur.ival,
                           cur.ttype, cur.text};
    assign m_axis_tuser = cur.kind;
    assign m_axis_tlast = cur.last;

endmodule
